/* hw/rtl/motor_feedback_unwrap_core_assert.svh */
// assertion macros for the motor feedback unwrap core
// no dependencies; included by files that carry concurrent checks
`ifndef MOTOR_FEEDBACK_UNWRAP_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_UNWRAP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mfu_pkg.sv */
// shared widths, register indexes and parameter defaults of the feedback unwrap core
// no dependencies
package mfu_pkg;

    localparam int ID_W       = 11;
    localparam int ANGLE_W    = 13;
    localparam int SPEED_W    = 16;
    localparam int TOTAL_W    = 29;
    localparam int SLOT_IDX_W = 3;
    localparam int CFG_IDX_W  = 3;

    localparam int MOTOR_SLOTS_DEF     = 4;
    localparam int COUNTS_PER_TURN_DEF = 8192;
    localparam int TURN_BITS_DEF       = 16;

    localparam int NUM_MOTOR_IDS = 4;

    localparam logic [SLOT_IDX_W-1:0] YAW_SLOT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOPBACK = 3'd5;

    localparam logic [ID_W-1:0] MOTOR0_ID_RST   = 11'd513;
    localparam logic [ID_W-1:0] MOTOR1_ID_RST   = 11'd514;
    localparam logic [ID_W-1:0] MOTOR2_ID_RST   = 11'd515;
    localparam logic [ID_W-1:0] MOTOR3_ID_RST   = 11'd516;
    localparam logic [ID_W-1:0] YAW_ID_RST      = 11'd517;
    localparam logic [ID_W-1:0] LOOPBACK_ID_RST = 11'd0;

endpackage

/* hw/rtl/mfu_if.sv */
// channel interfaces of the feedback unwrap core: frames in, results out, register writes
// depends on mfu_pkg
interface mfu_fb_if import mfu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ID_W-1:0]           frame_id;
    logic [ANGLE_W-1:0]        feedback_angle;
    logic signed [SPEED_W-1:0] feedback_speed;
    logic signed [SPEED_W-1:0] feedback_current;

    modport source (output valid, frame_id, feedback_angle, feedback_speed,
                    feedback_current, input ready);
    modport sink   (input valid, frame_id, feedback_angle, feedback_speed,
                    feedback_current, output ready);
endinterface

interface mfu_res_if import mfu_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      matched;
    logic [SLOT_IDX_W-1:0]     slot_index;
    logic signed [TOTAL_W-1:0] unwrapped_pos;
    logic signed [SPEED_W-1:0] turn_count;
    logic signed [SPEED_W-1:0] mean_speed;
    logic signed [SPEED_W-1:0] motor_current;
    logic [ANGLE_W-1:0]        first_angle;

    modport source (output valid, matched, slot_index, unwrapped_pos, turn_count,
                    mean_speed, motor_current, first_angle, input ready);
    modport sink   (input valid, matched, slot_index, unwrapped_pos, turn_count,
                    mean_speed, motor_current, first_angle, output ready);
endinterface

interface mfu_cfg_if import mfu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ID_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mfu_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module mfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/motor_feedback_unwrap_core.sv */
// motor feedback unwrap core: word registered in update stage, result in output register;
// one frame word per cycle unless the output stalls, set by the read-modify-write of the
// slot memory; the write of the previous word is forwarded to a read of the same slot
// reset (synchronous, active low): identifiers load their defaults, slot valid bits clear
// so every slot reads as zero, pipeline empties; no memory clearing pass is needed
// depends on mfu_pkg, mfu_if, mfu_ram and motor_feedback_unwrap_core_assert.svh
`include "motor_feedback_unwrap_core_assert.svh"

module motor_feedback_unwrap_core import mfu_pkg::*; #(
    parameter int MOTOR_SLOTS     = MOTOR_SLOTS_DEF,
    parameter int COUNTS_PER_TURN = COUNTS_PER_TURN_DEF,
    parameter int TURN_BITS       = TURN_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mfu_fb_if.sink   i_feedback,
    mfu_res_if.source o_result,
    mfu_cfg_if.sink  i_cfg
);

    localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int CPT_W  = $clog2(COUNTS_PER_TURN);
    localparam int DIFF_W = (CPT_W + 2 > ANGLE_W + 1) ? CPT_W + 2 : ANGLE_W + 1;
    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(COUNTS_PER_TURN / 2);
    localparam logic [TOTAL_W-1:0] CPT_MUL = TOTAL_W'(COUNTS_PER_TURN);

    // kind of the word in the update stage
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_MOTOR = 2'd1;
    localparam logic [1:0] K_YAW   = 2'd2;

    typedef struct packed {
        logic [ANGLE_W-1:0]   prev_angle;
        logic [SPEED_W-1:0]   prev_speed;
        logic [TURN_BITS-1:0] turns;
        logic [ANGLE_W-1:0]   origin_angle;
        logic                 start_taken;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    // configuration registers
    logic [ID_W-1:0] r_motor_id [NUM_MOTOR_IDS];
    logic [ID_W-1:0] r_yaw_id;
    logic [ID_W-1:0] r_loop_id;

    // update stage
    logic                      r_s1_valid;
    logic [1:0]                r_s1_kind;
    logic [SLOT_W-1:0]         r_s1_slot;
    logic [ANGLE_W-1:0]        r_s1_angle;
    logic signed [SPEED_W-1:0] r_s1_speed;
    logic signed [SPEED_W-1:0] r_s1_current;

    // forwarding of the write that happened alongside the read
    logic              r_fwd_valid;
    logic [SLOT_W-1:0] r_fwd_slot;
    t_slot_entry       r_fwd_entry;

    logic [MOTOR_SLOTS-1:0] r_slot_valid;

    // output register
    logic                      r_out_valid;
    logic                      r_out_matched;
    logic [SLOT_IDX_W-1:0]     r_out_slot;
    logic signed [TOTAL_W-1:0] r_out_total;
    logic signed [SPEED_W-1:0] r_out_turns;
    logic signed [SPEED_W-1:0] r_out_mean;
    logic signed [SPEED_W-1:0] r_out_current;
    logic [ANGLE_W-1:0]        r_out_first;

    logic              in_accept;
    logic              s1_go;
    logic              m_motor;
    logic              m_yaw;
    logic [SLOT_W-1:0] m_slot;
    logic [1:0]        m_kind;

    logic [ENTRY_W-1:0] rd_data;
    t_slot_entry        cur;
    t_slot_entry        n_entry;
    logic               fwd_hit;
    logic               wr_en;

    logic signed [SPEED_W:0]   speed_sum;
    logic signed [SPEED_W:0]   speed_adj;
    logic signed [SPEED_W-1:0] mean;
    logic signed [DIFF_W-1:0]  diff;
    logic [TURN_BITS-1:0]      turns_new;
    logic [TOTAL_W-1:0]        turns_ext;
    logic [TOTAL_W-1:0]        total;

    // handshakes
    assign s1_go     = r_s1_valid && (!r_out_valid || o_result.ready);
    assign in_accept = i_feedback.valid && i_feedback.ready;
    assign i_feedback.ready = !r_s1_valid || s1_go;
    assign i_cfg.ready = 1'b1;

    // identifier match, first register wins
    always_comb begin
        m_motor = 1'b0;
        m_slot  = '0;
        for (int i = NUM_MOTOR_IDS - 1; i >= 0; i--) begin
            if (i < MOTOR_SLOTS && i_feedback.frame_id == r_motor_id[i]) begin
                m_motor = 1'b1;
                m_slot  = SLOT_W'(i);
            end
        end
        m_yaw = !m_motor && (i_feedback.frame_id == r_yaw_id);
        if (m_motor) begin
            m_kind = K_MOTOR;
        end else if (m_yaw) begin
            m_kind = K_YAW;
        end else if (i_feedback.frame_id == r_loop_id) begin
            m_kind = K_MOTOR;
            m_slot = '0;
        end else begin
            m_kind = K_NONE;
        end
    end

    mfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MOTOR_SLOTS),
        .ADDR_W(SLOT_W)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_slot),
        .i_wr_data(n_entry),
        .i_rd_en  (in_accept),
        .i_rd_addr(m_slot),
        .o_rd_data(rd_data)
    );

    // read-modify-write of the slot entry
    always_comb begin
        fwd_hit = r_fwd_valid && (r_fwd_slot == r_s1_slot);
        if (fwd_hit) begin
            cur = r_fwd_entry;
        end else if (r_slot_valid[r_s1_slot]) begin
            cur = t_slot_entry'(rd_data);
        end else begin
            cur = '0;
        end

        // mean truncated toward zero: bias negative sums by one before the shift
        speed_sum = {r_s1_speed[SPEED_W-1], r_s1_speed}
                  + {cur.prev_speed[SPEED_W-1], cur.prev_speed};
        speed_adj = speed_sum + (SPEED_W+1)'(speed_sum[SPEED_W]);
        mean      = speed_adj[SPEED_W:1];

        diff = DIFF_W'(r_s1_angle) - DIFF_W'(cur.prev_angle);
        if (diff > HALF_TURN) begin
            turns_new = cur.turns - TURN_BITS'(1);
        end else if (diff < -HALF_TURN) begin
            turns_new = cur.turns + TURN_BITS'(1);
        end else begin
            turns_new = cur.turns;
        end

        turns_ext = TOTAL_W'($signed(turns_new));
        total     = turns_ext * CPT_MUL + TOTAL_W'(r_s1_angle);

        n_entry.prev_angle   = r_s1_angle;
        n_entry.prev_speed   = r_s1_speed;
        n_entry.turns        = turns_new;
        n_entry.origin_angle = cur.start_taken ? cur.origin_angle : r_s1_angle;
        n_entry.start_taken  = 1'b1;

        wr_en = s1_go && (r_s1_kind == K_MOTOR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_id[0] <= MOTOR0_ID_RST;
            r_motor_id[1] <= MOTOR1_ID_RST;
            r_motor_id[2] <= MOTOR2_ID_RST;
            r_motor_id[3] <= MOTOR3_ID_RST;
            r_yaw_id      <= YAW_ID_RST;
            r_loop_id     <= LOOPBACK_ID_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MOTOR0:   r_motor_id[0] <= i_cfg.data;
                REG_MOTOR1:   r_motor_id[1] <= i_cfg.data;
                REG_MOTOR2:   r_motor_id[2] <= i_cfg.data;
                REG_MOTOR3:   r_motor_id[3] <= i_cfg.data;
                REG_YAW:      r_yaw_id      <= i_cfg.data;
                REG_LOOPBACK: r_loop_id     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= wr_en;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_slot_valid[r_s1_slot] <= 1'b1;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind    <= m_kind;
            r_s1_slot    <= m_slot;
            r_s1_angle   <= i_feedback.feedback_angle;
            r_s1_speed   <= i_feedback.feedback_speed;
            r_s1_current <= i_feedback.feedback_current;
            r_fwd_slot   <= r_s1_slot;
            r_fwd_entry  <= n_entry;
        end
        if (s1_go) begin
            case (r_s1_kind)
                K_MOTOR: begin
                    r_out_matched <= 1'b1;
                    r_out_slot    <= SLOT_IDX_W'(r_s1_slot);
                    r_out_total   <= total;
                    r_out_turns   <= SPEED_W'($signed(turns_new));
                    r_out_mean    <= mean;
                    r_out_current <= r_s1_current;
                    r_out_first   <= n_entry.origin_angle;
                end
                K_YAW: begin
                    r_out_matched <= 1'b1;
                    r_out_slot    <= YAW_SLOT;
                    r_out_total   <= TOTAL_W'(r_s1_angle);
                    r_out_turns   <= '0;
                    r_out_mean    <= r_s1_speed;
                    r_out_current <= r_s1_current;
                    r_out_first   <= '0;
                end
                default: begin
                    r_out_matched <= 1'b0;
                    r_out_slot    <= '0;
                    r_out_total   <= '0;
                    r_out_turns   <= '0;
                    r_out_mean    <= '0;
                    r_out_current <= '0;
                    r_out_first   <= '0;
                end
            endcase
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.matched       = r_out_matched;
    assign o_result.slot_index    = r_out_slot;
    assign o_result.unwrapped_pos = r_out_total;
    assign o_result.turn_count    = r_out_turns;
    assign o_result.mean_speed    = r_out_mean;
    assign o_result.motor_current = r_out_current;
    assign o_result.first_angle   = r_out_first;

    // a forwarded entry always belongs to a slot that has been written
    `MFU_ASSERT_IMP(a_fwd_slot_written, i_clk, i_rst_n,
        r_s1_valid && fwd_hit, r_slot_valid[r_s1_slot], "forward from unwritten slot")

    // a full update stage behind a stalled output blocks new words
    `MFU_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n,
        r_out_valid && !o_result.ready && r_s1_valid, !i_feedback.ready,
        "input taken while update stage is stalled")

    // an unmatched word gives an all-zero result
    `MFU_ASSERT_NXT(a_nomatch_zero, i_clk, i_rst_n,
        s1_go && r_s1_kind == K_NONE,
        r_out_total == '0 && r_out_slot == '0 && r_out_first == '0 && r_out_mean == '0,
        "unmatched result is not zero")

endmodule
